>>> rtl/core/bsa_pkg.sv
// types, codes and helpers shared by the bitmap slot allocator files
`default_nettype none

package bsa_pkg;

    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // pool size; slot and count field widths are sized for it
    localparam int SLOTS = 2048;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 11;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 12;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0]  used_count;
        logic                was_used;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
    } result_t;

    // lowest clear bit of a word, with a flag that one exists
    function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) idx = BIT_W'(i);
        end
        return {~&w, idx};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bsa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_slot_allocator_top.sv
// bitmap slot allocator: first fit over a pool of slots held as words in a ram
//
// S_IDLE accepts a request and reads one 32-bit bitmap word from the ram,
// whose read data is registered; S_MOD then modifies that word, writes it
// back and loads the result register. Only one request is in flight: a
// new request is accepted only after the last one has left S_MOD.
// An allocate picks its word
// from a per-word full flag (lowest word with a free slot), then the lowest
// clear bit of that word. Per-word valid flags, cleared at reset, make a
// never-written word read as all free, so no clearing pass runs after reset.
// A result waiting on m_tready stalls only the write-back cycle.
`default_nettype none

module bitmap_slot_allocator_top
    import bsa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // slot_in[10:0], zero fill
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // slot_out[10:0], status[12:11],
                                        // was_used[13], used_count[25:14]
);

    localparam int WORDS     = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int LAST_BITS = SLOTS - (WORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_PAD = (LAST_BITS == WORD_W) ? '0 :
        ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    typedef enum logic {S_IDLE, S_MOD} state_t;

    state_t              state_reg, state_next;
    logic [WORDS-1:0]    full_reg, full_next;
    logic [WORDS-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    result_t             res_reg, res_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [WIDX_W-1:0]   addr_reg, addr_next;
    logic                in_range_reg, in_range_next;
    logic                pool_full_reg;

    logic                s_accept;
    logic [WIDX_W-1:0]   free_word;
    logic [WORD_W-1:0]   ram_rdata, word_q, eff, new_word;
    logic [BIT_W:0]      lz;
    logic [BIT_W-1:0]    bit_sel;
    logic [WORD_W-1:0]   onehot;
    logic                hit, proceed, ram_we;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // lowest word that still has a free slot
    always_comb begin
        free_word = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!full_reg[i]) free_word = WIDX_W'(i);
        end
    end

    assign in_range_next = (32'(s_tdata[SLOT_W-1:0]) < SLOTS);
    assign addr_next = (s_tuser == CMD_ALLOC) ? free_word :
                       WIDX_W'(s_tdata[SLOT_W-1:0] >> BIT_W);

    bsa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (new_word),
        .re    (s_accept),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    // modify stage
    assign word_q  = valid_reg[addr_reg] ? ram_rdata : '0;
    // slots past the pool end count as used
    assign eff     = word_q | ((addr_reg == WIDX_W'(WORDS - 1)) ? LAST_PAD : '0);
    assign lz      = lowest_zero(eff);
    assign bit_sel = (cmd_reg == CMD_ALLOC) ? lz[BIT_W-1:0] : slot_reg[BIT_W-1:0];
    assign onehot  = WORD_W'(1) << bit_sel;
    assign hit     = in_range_reg && word_q[bit_sel];
    assign proceed = (state_reg == S_MOD) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        full_next     = full_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        res_next      = res_reg;
        new_word      = word_q;
        ram_we        = 1'b0;
        if (s_accept) state_next = S_MOD;
        if (proceed) begin
            state_next          = S_IDLE;
            m_tvalid_next       = 1'b1;
            res_next.slot_out   = slot_reg;
            res_next.status     = STAT_OK;
            res_next.was_used   = 1'b0;
            unique case (cmd_reg)
                CMD_ALLOC: begin
                    res_next.slot_out = '0;
                    if (pool_full_reg) begin
                        res_next.status = STAT_FULL;
                    end else begin
                        new_word             = word_q | onehot;
                        ram_we               = 1'b1;
                        valid_next[addr_reg] = 1'b1;
                        full_next[addr_reg]  = &(eff | onehot);
                        cnt_next             = cnt_reg + CNT_W'(1);
                        res_next.slot_out    = SLOT_W'({addr_reg, lz[BIT_W-1:0]});
                    end
                end
                CMD_FREE: begin
                    if (hit) begin
                        new_word             = word_q & ~onehot;
                        ram_we               = 1'b1;
                        valid_next[addr_reg] = 1'b1;
                        full_next[addr_reg]  = 1'b0;
                        cnt_next             = cnt_reg - CNT_W'(1);
                        res_next.was_used    = 1'b1;
                    end else begin
                        res_next.status = STAT_NOT_USED;
                    end
                end
                default: begin
                    res_next.was_used = hit;
                end
            endcase
            res_next.used_count = COUNT_W'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            full_reg     <= '0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            full_reg     <= full_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        res_reg <= res_next;
        if (s_accept) begin
            cmd_reg       <= s_tuser;
            slot_reg      <= s_tdata[SLOT_W-1:0];
            addr_reg      <= addr_next;
            in_range_reg  <= in_range_next;
            pool_full_reg <= &full_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(32 - $bits(result_t)){1'b0}}, res_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= SLOTS)
        else $error("used count above pool size");

    a_all_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (&full_reg) |-> (32'(cnt_reg) == SLOTS))
        else $error("all words full but count short of pool size");

    a_empty_no_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (full_reg == '0))
        else $error("word marked full while pool empty");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && res_next.status == STAT_FULL) |-> (32'(cnt_reg) == SLOTS))
        else $error("pool full reported with free slots left");

    a_alloc_grants_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && cmd_reg == CMD_ALLOC && !pool_full_reg) |-> !eff[bit_sel])
        else $error("allocate granted a used slot");

endmodule

`default_nettype wire

>>> test/tb.sv
// testbench for the bitmap slot allocator: stimulus, occupancy predictor and result checks
`timescale 1ns / 1ps

module tb;
    import bsa_pkg::*;

    localparam int POOL = SLOTS;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // undefined code, behaves as check

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;    // slot_in[10:0], zero fill
    logic [1:0]        s_tuser = '0;    // cmd[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // slot_out[10:0], status[12:11],
                                        // was_used[13], used_count[25:14]
    bit                quiet = 1'b0;    // no idling on either side while set

    class pool_scoreboard;
        bit [POOL-1:0] used_bits;
        int unsigned   in_use;
        result_t       pending_results[$];
        int unsigned   faults, results_seen, requests;
        int unsigned   grants, fulls, releases, stale_frees, probes, peak;

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // first used slot at or after start, wrapping; start itself if the pool is empty
        function logic [SLOT_W-1:0] pick_used(logic [SLOT_W-1:0] start);
            int unsigned s;
            for (int i = 0; i < POOL; i++) begin
                s = (int'(start) + i) % POOL;
                if (used_bits[s]) return SLOT_W'(s);
            end
            return start;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot);
            result_t     r;
            int unsigned s;
            bit          hit;
            requests++;
            r.slot_out = slot;
            r.status   = STAT_OK;
            r.was_used = 1'b0;
            if (cmd == CMD_ALLOC) begin
                r.slot_out = '0;
                hit = 1'b0;
                for (s = 0; s < POOL; s++) begin
                    if (!used_bits[s]) begin
                        hit = 1'b1;
                        break;
                    end
                end
                if (hit) begin
                    used_bits[s] = 1'b1;
                    in_use++;
                    r.slot_out = SLOT_W'(s);
                    grants++;
                end else begin
                    r.status = STAT_FULL;
                    fulls++;
                end
            end else if (cmd == CMD_FREE) begin
                if (int'(slot) < POOL && used_bits[slot]) begin
                    r.was_used = 1'b1;
                    used_bits[slot] = 1'b0;
                    in_use--;
                    releases++;
                end else begin
                    r.status = STAT_NOT_USED;
                    stale_frees++;
                end
            end else begin
                r.was_used = int'(slot) < POOL && used_bits[slot];
                probes++;
            end
            r.used_count = COUNT_W'(in_use);
            if (in_use > peak) peak = in_use;
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display({"result %0d with no request outstanding: ",
                              "slot %0d status %0d used %0d count %0d"},
                             results_seen, got.slot_out, got.status, got.was_used,
                             got.used_count);
                return;
            end
            want = pending_results.pop_front();
            if (got.slot_out !== want.slot_out || got.status !== want.status ||
                got.was_used !== want.was_used || got.used_count !== want.used_count) begin
                faults++;
                if (faults <= 10)
                    $display({"result %0d mismatch: expected slot %0d status %0d ",
                              "used %0d count %0d, got slot %0d status %0d ",
                              "used %0d count %0d"},
                             results_seen, want.slot_out, want.status, want.was_used,
                             want.used_count, got.slot_out, got.status, got.was_used,
                             got.used_count);
            end
        endfunction
    endclass

    pool_scoreboard sb = new;

    bitmap_slot_allocator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result(result_t'(m_tdata[25:0]));
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot);
        if (!quiet && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, slot};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, slot);
    endtask

    task automatic random_request(int unsigned alloc_pct, int unsigned free_pct);
        int unsigned      r;
        logic [CMD_W-1:0] cmd;
        logic [SLOT_W-1:0] slot;
        r = $urandom_range(99);
        slot = SLOT_W'($urandom);
        if (r < alloc_pct) begin
            cmd = CMD_ALLOC;
        end else if (r < alloc_pct + free_pct) begin
            cmd = CMD_FREE;
            // mostly release something that is held
            if ($urandom_range(3) != 0) slot = sb.pick_used(slot);
        end else begin
            cmd = ($urandom_range(7) == 0) ? CMD_SPARE : CMD_CHECK;
            if ($urandom_range(1) != 0) slot = sb.pick_used(slot);
        end
        send_request(cmd, slot);
    endtask

    // hold off the sender until every outstanding request has its result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pool, first grants, holes, undefined code, field extremes
        send_request(CMD_CHECK, SLOT_W'(0));
        send_request(CMD_FREE, SLOT_W'(0));
        send_request(CMD_FREE, SLOT_W'(2047));
        send_request(CMD_ALLOC, SLOT_W'(2047));
        send_request(CMD_ALLOC, SLOT_W'(0));
        send_request(CMD_ALLOC, SLOT_W'(1365));
        send_request(CMD_CHECK, SLOT_W'(1));
        send_request(CMD_SPARE, SLOT_W'(2));
        send_request(CMD_SPARE, SLOT_W'(2047));
        send_request(CMD_FREE, SLOT_W'(1));
        send_request(CMD_CHECK, SLOT_W'(1));
        send_request(CMD_ALLOC, SLOT_W'(682));
        send_request(CMD_FREE, SLOT_W'(0));
        send_request(CMD_FREE, SLOT_W'(0));
        send_request(CMD_CHECK, SLOT_W'(1365));
        send_request(CMD_CHECK, SLOT_W'(682));
        send_request(CMD_ALLOC, SLOT_W'(0));
        send_request(CMD_FREE, SLOT_W'(2));
        send_request(CMD_ALLOC, SLOT_W'(0));
        send_request(CMD_ALLOC, SLOT_W'(0));
        send_request(CMD_CHECK, SLOT_W'(3));
        wait_drained();

        // mixed traffic at low occupancy
        repeat (50) random_request(50, 30);
        wait_drained();

        // fill the pool; first half with both sides running flat out
        quiet = 1'b1;
        while (sb.in_use < POOL) begin
            if (sb.in_use >= POOL / 2) quiet = 1'b0;
            random_request(98, 0);
        end
        quiet = 1'b0;
        repeat (10) send_request(CMD_ALLOC, SLOT_W'($urandom));

        // churn near full: holes get reused lowest first, full replies in between
        repeat (80) random_request(45, 45);
        wait_drained();

        // drain
        repeat (50) random_request(10, 70);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.pending() != 0) begin
            sb.faults += sb.pending();
            $display("%0d results never arrived", sb.pending());
        end
        $display("summary: %0d requests, %0d grants, %0d pool-full replies, peak %0d in use",
                 sb.requests, sb.grants, sb.fulls, sb.peak);
        $display("summary: %0d releases, %0d releases of free slots, %0d checks, %0d faults",
                 sb.releases, sb.stale_frees, sb.probes, sb.faults);
        if (sb.faults == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
